@@ src/pcocc_pkg.sv @@
// Shared types and constants for the phase current offset calibration block.
// Used by the top level and by the shared divider. No dependencies.
package pcocc_pkg;

    // Input item kinds
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_CAL   = 2'd1;
    localparam logic [1:0] KIND_CONV  = 2'd2;

    // Result kinds
    localparam logic [1:0] RK_CURRENTS = 2'd0;
    localparam logic [1:0] RK_CAL_DONE = 2'd1;
    localparam logic [1:0] RK_CAL_ERR  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_CAL_COUNT = 2'd0;
    localparam logic [1:0] CFG_GAIN_SEL  = 2'd1;
    localparam logic [1:0] CFG_LSB_UV    = 2'd2;

    localparam int CFG_W    = 16;
    localparam int LSB_W    = 11;
    localparam int GAIN_W   = 11;
    localparam int CUR_W    = 17;
    localparam int CUR_MAG_W = 16;

    localparam logic [CUR_MAG_W-1:0] CUR_LIMIT = 16'd60000;

    localparam logic [CFG_W-1:0] CAL_COUNT_RST = 16'd64;
    localparam logic [1:0]       GAIN_SEL_RST  = 2'd0;
    localparam logic [LSB_W-1:0] LSB_UV_RST    = 11'd806;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Amplifier gain in mV/A
    function automatic logic [GAIN_W-1:0] gain_mv(input logic [1:0] sel);
        logic [GAIN_W-1:0] g;
        case (sel)
            2'd0:    g = 11'd150;
            2'd1:    g = 11'd300;
            2'd2:    g = 11'd600;
            2'd3:    g = 11'd1200;
            default: g = 11'd150;
        endcase
        return g;
    endfunction

endpackage

@@ src/phase_current_offset_calibrate_convert.sv @@
// Three-phase current sense front end: offset calibration and mA conversion.
// Depends on pcocc_pkg and the shared divider pcocc_div.
//
// A start item clears the offsets and opens a calibration run (or reports a
// zero-count error); calibration items add one sample per phase, and the last
// one of a run divides each sum by the sample count. A conversion item
// subtracts the offset, multiplies by the microvolts-per-count register and
// divides by the selected gain, saturating at +-60000 mA. All divisions go
// through one restoring divider, one quotient bit per cycle over
// DW = max(ADC_BITS + COUNT_BITS, ADC_BITS + 11) bits, one phase after the
// other, and the input is not ready until the item is finished. An item with
// a result also waits while the previous result transfer is still pending.
module phase_current_offset_calibrate_convert import pcocc_pkg::*; #(
    parameter int ADC_BITS   = 12,
    parameter int COUNT_BITS = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [1:0]                 cfg_index,
    input  logic [CFG_W-1:0]           cfg_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_kind,
    input  logic [ADC_BITS-1:0]        s_sample_a,
    input  logic [ADC_BITS-1:0]        s_sample_b,
    input  logic [ADC_BITS-1:0]        s_sample_c,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [1:0]                 m_result_kind,
    output logic signed [CUR_W-1:0]    m_current_a,
    output logic signed [CUR_W-1:0]    m_current_b,
    output logic signed [CUR_W-1:0]    m_current_c,
    output logic [ADC_BITS-1:0]        m_offset_out_a,
    output logic [ADC_BITS-1:0]        m_offset_out_b,
    output logic [ADC_BITS-1:0]        m_offset_out_c
);

    localparam int SUM_W  = ADC_BITS + COUNT_BITS;
    localparam int PROD_W = ADC_BITS + LSB_W;
    localparam int DIVD_W = (SUM_W > PROD_W) ? SUM_W : PROD_W;
    localparam int DIVS_W = (COUNT_BITS > GAIN_W) ? COUNT_BITS : GAIN_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DGO,
        ST_DWAIT,
        ST_RESULT
    } state_t;

    state_t state_reg;

    logic [CFG_W-1:0] cal_count_reg;
    logic [1:0]       gain_sel_reg;
    logic [LSB_W-1:0] lsb_uv_reg;

    logic [SUM_W-1:0]      sums_reg [3];
    logic [COUNT_BITS-1:0] taken_reg;
    logic [ADC_BITS-1:0]   offs_reg [3];
    logic                  ofs_valid_reg;
    logic                  cal_reg;

    logic [ADC_BITS-1:0]    smp_reg [3];
    logic [1:0]             phase_reg;
    logic                   cal_mode_reg;
    logic                   neg_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic signed [CUR_W-1:0] cur_reg [3];
    logic [1:0]             res_kind_reg;

    logic                    m_valid_reg;
    logic [1:0]              m_kind_reg;
    logic signed [CUR_W-1:0] m_cur_reg [3];
    logic [ADC_BITS-1:0]     m_ofs_reg [3];

    logic [ADC_BITS-1:0]   in_smp [3];
    logic [COUNT_BITS-1:0] taken_next;
    logic                  cal_finish;
    logic [ADC_BITS:0]     delta;
    logic [ADC_BITS:0]     delta_abs;
    logic [PROD_W-1:0]     prod_next;

    logic              div_start;
    logic [DIVD_W-1:0] div_dividend;
    logic [DIVS_W-1:0] div_divisor;
    logic [DIVD_W-1:0] div_quot;
    div_stat_t         div_stat;

    logic [CUR_MAG_W-1:0] cur_mag;
    logic [CUR_W-1:0]     cur_next;

    assign in_smp[0] = s_sample_a;
    assign in_smp[1] = s_sample_b;
    assign in_smp[2] = s_sample_c;

    // counter saturates; the run ends at the count or at saturation
    assign taken_next = (taken_reg < COUNT_MAX) ? taken_reg + 1'b1 : taken_reg;
    assign cal_finish = (CFG_W'(taken_next) >= cal_count_reg) || (taken_next == COUNT_MAX);

    assign delta     = {1'b0, smp_reg[phase_reg]} - {1'b0, offs_reg[phase_reg]};
    assign delta_abs = delta[ADC_BITS] ? -delta : delta;
    assign prod_next = PROD_W'(delta_abs[ADC_BITS-1:0]) * PROD_W'(lsb_uv_reg);

    assign div_start    = (state_reg == ST_DGO);
    assign div_dividend = cal_mode_reg ? DIVD_W'(sums_reg[phase_reg]) : DIVD_W'(prod_reg);
    assign div_divisor  = cal_mode_reg ? DIVS_W'(taken_reg) : DIVS_W'(gain_mv(gain_sel_reg));

    assign cur_mag  = (div_quot > DIVD_W'(CUR_LIMIT)) ? CUR_LIMIT : div_quot[CUR_MAG_W-1:0];
    assign cur_next = neg_reg ? -{1'b0, cur_mag} : {1'b0, cur_mag};

    pcocc_div #(
        .DIVD_W (DIVD_W),
        .DIVS_W (DIVS_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quot),
        .stat     (div_stat)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_count_reg <= CAL_COUNT_RST;
            gain_sel_reg  <= GAIN_SEL_RST;
            lsb_uv_reg    <= LSB_UV_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_CAL_COUNT: cal_count_reg <= cfg_data;
                CFG_GAIN_SEL:  gain_sel_reg  <= cfg_data[1:0];
                CFG_LSB_UV:    lsb_uv_reg    <= cfg_data[LSB_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            ofs_valid_reg <= 1'b0;
            cal_reg       <= 1'b0;
            taken_reg     <= '0;
            phase_reg     <= '0;
            for (int i = 0; i < 3; i++) begin
                sums_reg[i] <= '0;
                offs_reg[i] <= '0;
            end
        end else begin
            // the result state loads the output register itself
            if (m_ready && state_reg != ST_RESULT) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        case (s_kind)
                            KIND_START: begin
                                if (cal_count_reg == '0) begin
                                    res_kind_reg <= RK_CAL_ERR;
                                    state_reg    <= ST_RESULT;
                                end else begin
                                    for (int i = 0; i < 3; i++) begin
                                        sums_reg[i] <= '0;
                                        offs_reg[i] <= '0;
                                    end
                                    taken_reg     <= '0;
                                    ofs_valid_reg <= 1'b0;
                                    cal_reg       <= 1'b1;
                                end
                            end
                            KIND_CAL: begin
                                if (cal_reg) begin
                                    for (int i = 0; i < 3; i++) begin
                                        sums_reg[i] <= sums_reg[i] + SUM_W'(in_smp[i]);
                                    end
                                    taken_reg <= taken_next;
                                    if (cal_finish) begin
                                        cal_mode_reg <= 1'b1;
                                        res_kind_reg <= RK_CAL_DONE;
                                        phase_reg    <= '0;
                                        state_reg    <= ST_DGO;
                                    end
                                end
                            end
                            KIND_CONV: begin
                                if (ofs_valid_reg) begin
                                    for (int i = 0; i < 3; i++) begin
                                        smp_reg[i] <= in_smp[i];
                                    end
                                    cal_mode_reg <= 1'b0;
                                    res_kind_reg <= RK_CURRENTS;
                                    phase_reg    <= '0;
                                    state_reg    <= ST_MUL;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_MUL: begin
                    neg_reg   <= delta[ADC_BITS];
                    prod_reg  <= prod_next;
                    state_reg <= ST_DGO;
                end
                ST_DGO: begin
                    state_reg <= ST_DWAIT;
                end
                ST_DWAIT: begin
                    if (div_stat.done) begin
                        if (cal_mode_reg) begin
                            offs_reg[phase_reg] <= div_quot[ADC_BITS-1:0];
                        end else begin
                            cur_reg[phase_reg] <= cur_next;
                        end
                        if (phase_reg == 2'd2) begin
                            if (cal_mode_reg) begin
                                ofs_valid_reg <= 1'b1;
                                cal_reg       <= 1'b0;
                            end
                            state_reg <= ST_RESULT;
                        end else begin
                            phase_reg <= phase_reg + 1'b1;
                            state_reg <= cal_mode_reg ? ST_DGO : ST_MUL;
                        end
                    end
                end
                ST_RESULT: begin
                    // wait for the output register to be free
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_kind_reg  <= res_kind_reg;
                        for (int i = 0; i < 3; i++) begin
                            m_cur_reg[i] <= (res_kind_reg == RK_CURRENTS) ? cur_reg[i] : '0;
                            m_ofs_reg[i] <= (res_kind_reg == RK_CAL_DONE) ? offs_reg[i] : '0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_result_kind  = m_kind_reg;
    assign m_current_a    = m_cur_reg[0];
    assign m_current_b    = m_cur_reg[1];
    assign m_current_c    = m_cur_reg[2];
    assign m_offset_out_a = m_ofs_reg[0];
    assign m_offset_out_b = m_ofs_reg[1];
    assign m_offset_out_c = m_ofs_reg[2];

`ifndef SYNTHESIS
    a_valid_cal_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ofs_valid_reg && cal_reg))
        else $error("offsets valid during a calibration run");

    a_div_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> state_reg == ST_DWAIT)
        else $error("divider finished outside of its wait state");

    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_cur_no_offsets: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_result_kind == RK_CURRENTS) |->
            (m_offset_out_a == '0 && m_offset_out_b == '0 && m_offset_out_c == '0))
        else $error("current transfer carries offsets");
`endif

endmodule

@@ src/pcocc_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
// Depends on pcocc_pkg for the status struct.
module pcocc_div import pcocc_pkg::*; #(
    parameter int DIVD_W = 28,
    parameter int DIVS_W = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [DIVS_W-1:0] divisor,
    output logic [DIVD_W-1:0] quotient,
    output div_stat_t         stat
);

    localparam int CNT_W = $clog2(DIVD_W + 1);

    logic [DIVD_W-1:0] quot_reg;
    logic [DIVS_W-1:0] rem_reg;
    logic [DIVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DIVS_W:0] trial;
    logic [DIVS_W:0] diff;

    assign trial = {rem_reg, quot_reg[DIVD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            // one-cycle pulse on the last quotient bit
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (start && !busy_reg) begin
                quot_reg <= dividend;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
                cnt_reg  <= CNT_W'(DIVD_W);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                // no borrow means the trial remainder covers the divisor
                if (!diff[DIVS_W]) begin
                    rem_reg <= diff[DIVS_W-1:0];
                end else begin
                    rem_reg <= trial[DIVS_W-1:0];
                end
                quot_reg <= {quot_reg[DIVD_W-2:0], ~diff[DIVS_W]};
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign quotient  = quot_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for phase_current_offset_calibrate_convert.
// Needs only pcocc_pkg and the block's RTL; predicts every result in-bench.
`timescale 1ns / 1ps

module testbench;
    import pcocc_pkg::*;

    localparam longint MA_LIMIT     = 60000;
    localparam int     QUIET_CYCLES = 128;     // > one full three-phase divide
    localparam int     CYCLE_LIMIT  = 1000000;
    localparam int     PHASE_ITEMS  = 350;
    localparam logic [1:0] KIND_RSVD = 2'd3;   // unused kind, dropped by the block

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [16:0] cur_a;
        logic signed [16:0] cur_b;
        logic signed [16:0] cur_c;
        logic [11:0]        ofs_a;
        logic [11:0]        ofs_b;
        logic [11:0]        ofs_c;
    } reading_t;

    logic               aclk;
    logic               aresetn   = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [1:0]         cfg_index = CFG_CAL_COUNT;
    logic [CFG_W-1:0]   cfg_data  = '0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    logic [1:0]         s_kind    = KIND_START;
    logic [11:0]        s_sample_a = '0;
    logic [11:0]        s_sample_b = '0;
    logic [11:0]        s_sample_c = '0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    logic [1:0]         m_result_kind;
    logic signed [16:0] m_current_a;
    logic signed [16:0] m_current_b;
    logic signed [16:0] m_current_c;
    logic [11:0]        m_offset_out_a;
    logic [11:0]        m_offset_out_b;
    logic [11:0]        m_offset_out_c;

    phase_current_offset_calibrate_convert dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_sample_a     (s_sample_a),
        .s_sample_b     (s_sample_b),
        .s_sample_c     (s_sample_c),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_kind  (m_result_kind),
        .m_current_a    (m_current_a),
        .m_current_b    (m_current_b),
        .m_current_c    (m_current_c),
        .m_offset_out_a (m_offset_out_a),
        .m_offset_out_b (m_offset_out_b),
        .m_offset_out_c (m_offset_out_c)
    );

    // Shadow of the block: registers and calibration state
    logic [15:0] cal_count;
    logic [1:0]  gain_sel;
    logic [10:0] lsb_uv;
    logic [27:0] chan_sum [3];
    logic [15:0] taken;
    logic [11:0] chan_ofs [3];
    logic        ofs_valid;
    logic        cal_active;

    reading_t queued_readings [$];

    int errors         = 0;
    int cycle_count    = 0;
    int effective_items = 0;
    int currents_seen  = 0;
    int cal_done_seen  = 0;
    int cal_err_seen   = 0;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[%0t] timeout, %0d results still awaited", $time,
                     queued_readings.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(negedge aclk)
        m_ready <= ($urandom_range(99) >= receiver_stall_pct);

    // ---------------------------------------------------------------- predictor

    function automatic logic signed [16:0] milliamps(input logic [11:0] smp,
                                                     input logic [11:0] ofs);
        longint delta;
        longint scale;
        longint gain;
        longint ma;
        delta = smp;
        delta = delta - longint'({1'b0, ofs});
        scale = lsb_uv;
        case (gain_sel)
            2'd0:    gain = 150;
            2'd1:    gain = 300;
            2'd2:    gain = 600;
            default: gain = 1200;
        endcase
        ma = (delta * scale) / gain;      // signed divide truncates toward zero
        if (ma > MA_LIMIT)  ma = MA_LIMIT;
        if (ma < -MA_LIMIT) ma = -MA_LIMIT;
        return ma[16:0];
    endfunction

    task automatic reset_shadow();
        cal_count  = CAL_COUNT_RST;
        gain_sel   = GAIN_SEL_RST;
        lsb_uv     = LSB_UV_RST;
        for (int i = 0; i < 3; i++) begin
            chan_sum[i] = '0;
            chan_ofs[i] = '0;
        end
        taken      = '0;
        ofs_valid  = 1'b0;
        cal_active = 1'b0;
    endtask

    task automatic predict_reading(input logic [1:0] kind, input logic [11:0] a,
                                   input logic [11:0] b, input logic [11:0] c);
        reading_t    r;
        logic [11:0] smp [3];
        r = '0;
        smp[0] = a;
        smp[1] = b;
        smp[2] = c;
        case (kind)
            KIND_START: begin
                effective_items++;
                if (cal_count == 0) begin
                    r.kind = RK_CAL_ERR;
                    queued_readings.push_back(r);
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        chan_sum[i] = '0;
                        chan_ofs[i] = '0;
                    end
                    taken      = '0;
                    ofs_valid  = 1'b0;
                    cal_active = 1'b1;
                end
            end
            KIND_CAL: begin
                if (cal_active) begin
                    effective_items++;
                    for (int i = 0; i < 3; i++)
                        chan_sum[i] = chan_sum[i] + smp[i];
                    if (taken != 16'hFFFF)
                        taken = taken + 1'b1;
                    if (taken >= cal_count || taken == 16'hFFFF) begin
                        for (int i = 0; i < 3; i++)
                            chan_ofs[i] = 12'(chan_sum[i] / taken);
                        ofs_valid  = 1'b1;
                        cal_active = 1'b0;
                        r.kind  = RK_CAL_DONE;
                        r.ofs_a = chan_ofs[0];
                        r.ofs_b = chan_ofs[1];
                        r.ofs_c = chan_ofs[2];
                        queued_readings.push_back(r);
                    end
                end
            end
            KIND_CONV: begin
                if (ofs_valid) begin
                    effective_items++;
                    r.kind  = RK_CURRENTS;
                    r.cur_a = milliamps(a, chan_ofs[0]);
                    r.cur_b = milliamps(b, chan_ofs[1]);
                    r.cur_c = milliamps(c, chan_ofs[2]);
                    queued_readings.push_back(r);
                end
            end
            default: ;  // kind 3 is dropped
        endcase
    endtask

    // ---------------------------------------------------------------- checker

    task automatic compare_field(input string name, input longint want,
                                 input longint got);
        if (want != got) begin
            $display("[%0t] %s mismatch: expected %0d, actual %0d", $time, name,
                     want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        reading_t want;
        if (aresetn && m_valid && m_ready) begin
            if (queued_readings.size() == 0) begin
                $display("[%0t] unexpected result: expected none, actual kind %0d",
                         $time, m_result_kind);
                errors++;
            end else begin
                want = queued_readings.pop_front();
                compare_field("result_kind", want.kind, m_result_kind);
                compare_field("current_a", $signed(want.cur_a), $signed(m_current_a));
                compare_field("current_b", $signed(want.cur_b), $signed(m_current_b));
                compare_field("current_c", $signed(want.cur_c), $signed(m_current_c));
                compare_field("offset_out_a", want.ofs_a, m_offset_out_a);
                compare_field("offset_out_b", want.ofs_b, m_offset_out_b);
                compare_field("offset_out_c", want.ofs_c, m_offset_out_c);
                case (want.kind)
                    RK_CURRENTS: currents_seen++;
                    RK_CAL_DONE: cal_done_seen++;
                    default:     cal_err_seen++;
                endcase
            end
        end
    end

    // ---------------------------------------------------------------- drivers

    task automatic send_item(input logic [1:0] kind, input logic [11:0] a,
                             input logic [11:0] b, input logic [11:0] c);
        @(negedge aclk);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_kind     <= kind;
        s_sample_a <= a;
        s_sample_b <= b;
        s_sample_c <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_reading(kind, a, b, c);
    endtask

    // Hold the input off until every awaited result is out and the divider
    // has had time to finish any item that produces nothing.
    task automatic wait_quiet();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (queued_readings.size() != 0) @(negedge aclk);
        repeat (QUIET_CYCLES) @(negedge aclk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] value);
        @(negedge aclk);
        s_valid   <= 1'b0;
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_CAL_COUNT: cal_count = value;
            CFG_GAIN_SEL:  gain_sel  = value[1:0];
            CFG_LSB_UV:    lsb_uv    = value[10:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [11:0] adc_sample();
        int pick;
        pick = $urandom_range(99);
        if (pick < 5)  return 12'd0;
        if (pick < 10) return 12'hFFF;
        if (pick < 55) return 12'(2048 - 96 + $urandom_range(191));
        return 12'($urandom_range(4095));
    endfunction

    task automatic randomize_settings();
        int          pick;
        logic [15:0] value;
        pick = $urandom_range(99);
        if (pick < 6)       value = 16'd0;
        else if (pick < 66) value = 16'($urandom_range(1, 8));
        else if (pick < 94) value = 16'($urandom_range(9, 40));
        else                value = 16'($urandom_range(100, 300));
        cfg_write(CFG_CAL_COUNT, value);

        value = 16'($urandom_range(3));
        if ($urandom_range(99) < 30) value = value | (16'($urandom) & 16'hFFFC);
        cfg_write(CFG_GAIN_SEL, value);

        pick = $urandom_range(99);
        if (pick < 10)      value = 16'd1;
        else if (pick < 20) value = 16'd2047;
        else if (pick < 25) value = 16'd0;
        else                value = 16'($urandom_range(1, 2047));
        if ($urandom_range(99) < 30) value = value | (16'($urandom) & 16'hF800);
        cfg_write(CFG_LSB_UV, value);
    endtask

    // A calibration run with random content, a few stray items, maybe a count
    // change or a restart in the middle, then a burst of conversions.
    task automatic calibrate_then_convert();
        bit recounted;
        int pick;
        recounted = 1'b0;
        send_item(KIND_START, adc_sample(), adc_sample(), adc_sample());
        while (cal_active) begin
            pick = $urandom_range(99);
            if (pick < 4) begin
                send_item(KIND_START, adc_sample(), adc_sample(), adc_sample());
            end else if (pick < 10) begin
                send_item($urandom_range(99) < 50 ? KIND_CONV : KIND_RSVD,
                          adc_sample(), adc_sample(), adc_sample());
            end else if (pick < 12 && !recounted) begin
                recounted = 1'b1;
                wait_quiet();
                cfg_write(CFG_CAL_COUNT, 16'($urandom_range(0, taken + 3)));
            end else begin
                send_item(KIND_CAL, adc_sample(), adc_sample(), adc_sample());
            end
        end
        repeat ($urandom_range(1, 8))
            send_item($urandom_range(99) < 90 ? KIND_CONV : KIND_RSVD,
                      adc_sample(), adc_sample(), adc_sample());
    endtask

    task automatic noise_item();
        logic [1:0] kind;
        kind = 2'($urandom_range(3));
        if (kind == KIND_START && $urandom_range(99) < 50) begin
            // broken run: partial calibration left dangling
            send_item(KIND_START, adc_sample(), adc_sample(), adc_sample());
            send_item(KIND_CAL, adc_sample(), adc_sample(), adc_sample());
            send_item(KIND_CONV, adc_sample(), adc_sample(), adc_sample());
        end else begin
            send_item(kind, 12'($urandom_range(4095)), 12'($urandom_range(4095)),
                      12'($urandom_range(4095)));
        end
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_reset_defaults();
        send_item(KIND_CONV, 12'd100, 12'd2000, 12'd4095);  // offsets not valid
        send_item(KIND_CAL, 12'd1, 12'd2, 12'd3);           // not calibrating
        send_item(KIND_RSVD, 12'hFFF, 12'hFFF, 12'hFFF);
        send_item(KIND_START, 12'd0, 12'd0, 12'd0);         // count 64 from reset
        while (cal_active)
            send_item(KIND_CAL, adc_sample(), adc_sample(), adc_sample());
        repeat (3) send_item(KIND_CONV, adc_sample(), adc_sample(), adc_sample());
    endtask

    task automatic test_start_handling();
        wait_quiet();
        cfg_write(CFG_CAL_COUNT, 16'd0);
        send_item(KIND_START, 12'd5, 12'd6, 12'd7);
        wait_quiet();
        cfg_write(CFG_CAL_COUNT, 16'd3);
        send_item(KIND_START, 12'd0, 12'd0, 12'd0);
        send_item(KIND_CAL, 12'd4000, 12'd10, 12'd2222);
        send_item(KIND_START, 12'd0, 12'd0, 12'd0);          // restart mid-run
        send_item(KIND_CAL, 12'd2048, 12'd2050, 12'd2047);
        // zero count mid-run: error reported, run keeps going
        wait_quiet();
        cfg_write(CFG_CAL_COUNT, 16'd0);
        send_item(KIND_START, 12'd0, 12'd0, 12'd0);
        wait_quiet();
        cfg_write(CFG_CAL_COUNT, 16'd3);
        send_item(KIND_CAL, 12'd2049, 12'd2047, 12'd2046);
        send_item(KIND_CAL, 12'd2050, 12'd2046, 12'd2045);
    endtask

    task automatic test_offset_extremes();
        wait_quiet();
        cfg_write(CFG_CAL_COUNT, 16'd2);
        cfg_write(CFG_GAIN_SEL, 16'd0);
        cfg_write(CFG_LSB_UV, 16'd2047);
        send_item(KIND_START, 12'd0, 12'd0, 12'd0);
        send_item(KIND_CAL, 12'hFFF, 12'hFFF, 12'hFFF);
        send_item(KIND_CAL, 12'hFFF, 12'hFFF, 12'hFFF);
        send_item(KIND_CONV, 12'd0, 12'd0, 12'd0);
        send_item(KIND_CONV, 12'hFFF, 12'hFFF, 12'hFFF);
        send_item(KIND_START, 12'd0, 12'd0, 12'd0);
        send_item(KIND_CAL, 12'd0, 12'hFFF, 12'd2000);
        send_item(KIND_CAL, 12'd1, 12'hFFF, 12'd2001);
        // phase C one count low: truncation toward zero gives -13, not -14
        send_item(KIND_CONV, 12'hFFF, 12'd0, 12'd1999);
        send_item(KIND_CONV, 12'd0, 12'hFFF, 12'd2001);
    endtask

    task automatic test_gain_and_scale();
        for (int g = 0; g < 4; g++) begin
            wait_quiet();
            cfg_write(CFG_GAIN_SEL, 16'(g));
            cfg_write(CFG_LSB_UV, g[0] ? 16'd1 : 16'd806);
            send_item(KIND_CONV, adc_sample(), adc_sample(), 12'd1990);
        end
        wait_quiet();
        cfg_write(CFG_LSB_UV, 16'd0);
        send_item(KIND_CONV, 12'hFFF, 12'd0, 12'd123);
    endtask

    task automatic test_count_change_mid_run();
        wait_quiet();
        cfg_write(CFG_CAL_COUNT, 16'hFFFF);
        cfg_write(CFG_LSB_UV, 16'd806);
        send_item(KIND_START, 12'd0, 12'd0, 12'd0);
        repeat (3) send_item(KIND_CAL, adc_sample(), adc_sample(), adc_sample());
        wait_quiet();
        cfg_write(CFG_CAL_COUNT, 16'd2);                     // already passed
        send_item(KIND_CAL, adc_sample(), adc_sample(), adc_sample());
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct);
        int goal;
        goal = effective_items + PHASE_ITEMS;
        wait_quiet();
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        while (effective_items < goal) begin
            wait_quiet();
            randomize_settings();
            repeat ($urandom_range(2, 6)) begin
                if ($urandom_range(99) < 75) calibrate_then_convert();
                else                         noise_item();
            end
        end
    endtask

    initial begin
        reset_shadow();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_start_handling();
        test_offset_extremes();
        test_gain_and_scale();
        test_count_change_mid_run();
        test_random_phase(0, 0);
        test_random_phase(67, 0);
        test_random_phase(0, 67);
        test_random_phase(21, 21);

        wait_quiet();
        $display("Covered %0d effective items: %0d current readings, %0d calibrations,",
                 effective_items, currents_seen, cal_done_seen);
        $display("%0d zero-count errors, under four idle/stall mixes; %0d mismatches",
                 cal_err_seen, errors);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
